// ===== src/svc_pkg.sv =====
// Shared types, constants and helpers for the strided convolution unit.
// No dependencies; every file except svc_ram and svc_div uses this package.
`timescale 1ns / 1ps
package svc_pkg;

    localparam int DATA_W      = 16;
    localparam int MAX_KERNEL  = 5;
    localparam int MAX_KERNELS = 4;
    localparam int MAX_HEIGHT  = 1024;
    localparam int DEF_MAX_WIDTH = 1024;

    localparam int IMG_W    = 11;
    localparam int KSZ_W    = 3;
    localparam int STEP_W   = 4;
    localparam int KCNT_W   = 3;
    localparam int KSEL_W   = 2;
    localparam int CIDX_W   = 3;
    localparam int OUT_IDX_W = 10;
    localparam int SUM_W    = 40;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 11;
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 64;

    localparam int WIN_N   = MAX_KERNEL * MAX_KERNEL;
    localparam int COEF_N  = MAX_KERNELS * WIN_N;
    localparam int COEF_AW = $clog2(COEF_N);
    localparam int BANK_W  = $clog2(MAX_KERNEL);
    localparam int CSUM_W  = DATA_W + $clog2(MAX_KERNELS);
    localparam int PROD_W  = DATA_W + CSUM_W;
    localparam int FIFO_DEPTH = 4;

    localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_KERNEL_WIDTH  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_KERNEL_HEIGHT = 3'd3;
    localparam logic [CFG_AW-1:0] REG_STEP_SIZE     = 3'd4;
    localparam logic [CFG_AW-1:0] REG_KERNEL_COUNT  = 3'd5;

    localparam logic CMD_COEF  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    typedef enum logic [1:0] {SEQ_IDLE, SEQ_START, SEQ_WAIT} seq_state_t;
    typedef enum logic {JOB_COEF, JOB_WIN} job_kind_t;

    typedef struct packed {
        logic [IMG_W-1:0]  image_width;
        logic [IMG_W-1:0]  image_height;
        logic [KSZ_W-1:0]  kernel_width;
        logic [KSZ_W-1:0]  kernel_height;
        logic [STEP_W-1:0] step_size;
        logic [KCNT_W-1:0] kernel_count;
    } cfg_t;

    typedef struct packed {
        job_kind_t                       kind;
        logic [COEF_AW-1:0]              coef_idx;
        logic [DATA_W-1:0]               coef_val;
        logic [WIN_N-1:0][DATA_W-1:0]    win;
        logic [OUT_IDX_W-1:0]            out_col;
        logic [OUT_IDX_W-1:0]            out_row;
        logic                            last;
    } job_t;

    // kernel size clamp to 1..MAX_KERNEL
    function automatic logic [KSZ_W-1:0] clamp_ksz(input logic [KSZ_W-1:0] v);
        logic [KSZ_W-1:0] r;
        r = v;
        if (v == '0) r = KSZ_W'(1);
        else if (int'(v) > MAX_KERNEL) r = KSZ_W'(MAX_KERNEL);
        return r;
    endfunction

endpackage

// ===== src/svc_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module svc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== src/svc_div.sv =====
// Restoring divider, one quotient bit per cycle, 4-bit divisor.
// Depends on nothing; used by svc_front for stride bookkeeping.
`timescale 1ns / 1ps
module svc_div #(
    parameter int DW = 11
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [3:0]    divisor,
    output logic          done,
    output logic [DW-1:0] quotient,
    output logic [3:0]    remainder
);
    localparam int CNT_W = $clog2(DW + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    quo_reg;
    logic [3:0]       rem_reg;
    logic             done_reg;
    logic [4:0]       trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= CNT_W'(DW);
            done_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == CNT_W'(1));
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (cnt_reg != '0) begin
            // remainder stays below the divisor, so 4 bits hold it
            rem_reg <= fits ? 4'(trial - {1'b0, divisor}) : trial[3:0];
            quo_reg <= {quo_reg[DW-2:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

// ===== src/svc_fifo.sv =====
// Short job queue between the front end and the MAC back end.
// Depends on svc_pkg (job_t).
`timescale 1ns / 1ps
module svc_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  svc_pkg::job_t              push_data,
    input  logic                       pop,
    output svc_pkg::job_t              pop_data,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    import svc_pkg::*;
    localparam int PW = $clog2(DEPTH);

    job_t                     mem_reg [DEPTH];
    logic [PW-1:0]            wptr_reg, rptr_reg;
    logic [$clog2(DEPTH+1)-1:0] cnt_reg;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (int'(p) == DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) wptr_reg <= ptr_inc(wptr_reg);
            if (pop)  rptr_reg <= ptr_inc(rptr_reg);
            if (push && !pop)      cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wptr_reg] <= push_data;
    end

    assign pop_data = mem_reg[rptr_reg];
    assign empty    = (cnt_reg == '0);
    assign count    = cnt_reg;
endmodule

// ===== src/svc_front.sv =====
// Front end: accepts beats, tracks raster position and stride phase,
// keeps the line buffers and window columns, and queues coefficient and
// window jobs. Depends on svc_pkg, svc_ram and svc_div.
`timescale 1ns / 1ps
module svc_front #(
    parameter int MAX_WIDTH = svc_pkg::DEF_MAX_WIDTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  svc_pkg::cfg_t               cfg,
    input  logic                        recalc,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_command,
    input  logic [svc_pkg::KSEL_W-1:0]  s_kernel_select,
    input  logic [svc_pkg::CIDX_W-1:0]  s_coef_col,
    input  logic [svc_pkg::CIDX_W-1:0]  s_coef_row,
    input  logic [svc_pkg::DATA_W-1:0]  s_value,
    input  logic [$clog2(svc_pkg::FIFO_DEPTH+1)-1:0] fifo_count,
    output logic                        push,
    output svc_pkg::job_t               push_job
);
    import svc_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int DW = (WW > IMG_W) ? WW : IMG_W;
    localparam int MK = MAX_KERNEL;

    localparam logic [1:0] OP_COL   = 2'd0;
    localparam logic [1:0] OP_ROW   = 2'd1;
    localparam logic [1:0] OP_WSPAN = 2'd2;
    localparam logic [1:0] OP_HSPAN = 2'd3;

    // ---- clamped configuration
    logic [DW-1:0]     w_c;
    logic [IMG_W-1:0]  h_c;
    logic [KSZ_W-1:0]  kw_c, kh_c;
    logic [STEP_W-1:0] s_c;

    always_comb begin
        w_c = DW'(cfg.image_width);
        if (cfg.image_width == '0) w_c = DW'(1);
        else if (DW'(cfg.image_width) > DW'(MAX_WIDTH)) w_c = DW'(MAX_WIDTH);
        h_c = cfg.image_height;
        if (cfg.image_height == '0) h_c = IMG_W'(1);
        else if (int'(cfg.image_height) > MAX_HEIGHT) h_c = IMG_W'(MAX_HEIGHT);
        kw_c = clamp_ksz(cfg.kernel_width);
        kh_c = clamp_ksz(cfg.kernel_height);
        s_c  = (cfg.step_size == '0) ? STEP_W'(1) : cfg.step_size;
    end

    // (kernel size - 1) split by the stride: few steps on narrow values
    function automatic logic [5:0] kdiv(input logic [KSZ_W-1:0] k, input logic [3:0] s);
        logic [KSZ_W-1:0] rem;
        logic [2:0]       q;
        rem = k - 1'b1;
        q   = '0;
        for (int n = 0; n < MK; n++) begin
            if ({1'b0, rem} >= s) begin
                rem = KSZ_W'({1'b0, rem} - s);
                q   = q + 1'b1;
            end
        end
        return {q, rem};
    endfunction

    function automatic logic [4:0] rem_inc(input logic [3:0] r, input logic [3:0] s);
        logic [3:0] n;
        n = r + 1'b1;
        return (n == s) ? {1'b1, 4'd0} : {1'b0, n};
    endfunction

    logic [5:0] kdc, kdr;
    assign kdc = kdiv(kw_c, s_c);
    assign kdr = kdiv(kh_c, s_c);

    // ---- position state
    logic [CW-1:0]        col_reg, colq_reg;
    logic [3:0]           colr_reg, rowr_reg;
    logic [OUT_IDX_W-1:0] row_reg, rowq_reg;
    logic [BANK_W-1:0]    bank_reg;
    logic [CW-1:0]        qcw_reg;
    logic [OUT_IDX_W-1:0] qrh_reg;

    // ---- recompute sequencer
    seq_state_t state_reg, state_next;
    logic [1:0] op_reg;
    logic       div_start, busy, div_done;
    logic [DW-1:0] div_a, div_q;
    logic [3:0]    div_r;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE:  state_next = SEQ_IDLE;
            SEQ_START: state_next = SEQ_WAIT;
            SEQ_WAIT:  if (div_done) begin
                state_next = (op_reg == OP_HSPAN) ? SEQ_IDLE : SEQ_START;
            end
            default:   state_next = SEQ_START;
        endcase
        if (recalc) state_next = SEQ_START;
    end

    always_comb begin
        div_start = 1'b0;
        busy      = 1'b1;
        case (state_reg)
            SEQ_IDLE:  busy = 1'b0;
            SEQ_START: div_start = 1'b1;
            SEQ_WAIT:  busy = 1'b1;
            default:   busy = 1'b1;
        endcase
    end

    always_comb begin
        case (op_reg)
            OP_COL:   div_a = DW'(col_reg);
            OP_ROW:   div_a = DW'(row_reg);
            OP_WSPAN: div_a = (DW'(kw_c) <= w_c) ? w_c - DW'(kw_c) : '0;
            OP_HSPAN: div_a = (IMG_W'(kh_c) <= h_c) ? DW'(h_c - IMG_W'(kh_c)) : '0;
            default:  div_a = '0;
        endcase
    end

    svc_div #(.DW(DW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_a),
        .divisor(s_c), .done(div_done), .quotient(div_q), .remainder(div_r)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_START;
            op_reg    <= OP_COL;
        end else begin
            state_reg <= state_next;
            if (recalc) op_reg <= OP_COL;
            else if (state_reg == SEQ_WAIT && div_done) op_reg <= op_reg + 1'b1;
        end
    end

    // ---- accept and classify
    logic accept, acc_pix, acc_coef, coef_ok, p1_push_now;
    logic p1_pix_reg, p1_coef_reg;

    assign p1_push_now = p1_coef_reg || (p1_pix_reg && p1_emit_reg);
    assign s_ready  = !busy && !recalc && ((int'(fifo_count) + int'(p1_push_now)) < FIFO_DEPTH);
    assign accept   = s_valid && s_ready;
    assign acc_pix  = accept && (s_command == CMD_PIXEL);
    assign coef_ok  = (int'(s_kernel_select) < MAX_KERNELS) && (int'(s_coef_col) < MK)
                      && (int'(s_coef_row) < MK);
    assign acc_coef = accept && (s_command == CMD_COEF) && coef_ok;

    // current pixel position after the start-of-pixel wraps
    logic                 colwrap, rowwrap, emit, colend;
    logic [CW-1:0]        c, cq;
    logic [3:0]           cr, rr;
    logic [OUT_IDX_W-1:0] r, rq;
    logic [BANK_W-1:0]    rb;
    logic [IMG_W-1:0]     ra;
    logic [OUT_IDX_W-1:0] raq;
    logic [3:0]           rar;
    logic [BANK_W-1:0]    rab;
    logic [4:0]           ri, ci, ri2;
    logic [CW-1:0]        lq;
    logic [OUT_IDX_W-1:0] tq;
    logic [CW+OUT_IDX_W-1:0] lq_ext;
    logic [IMG_W-1:0]     rnext;

    function automatic logic [BANK_W-1:0] bank_inc(input logic [BANK_W-1:0] b);
        return (int'(b) == MK - 1) ? '0 : b + 1'b1;
    endfunction

    always_comb begin
        colwrap = DW'(col_reg) >= w_c;
        c  = colwrap ? '0 : col_reg;
        cq = colwrap ? '0 : colq_reg;
        cr = colwrap ? '0 : colr_reg;
        ri = rem_inc(rowr_reg, s_c);
        ra  = colwrap ? IMG_W'(row_reg) + 1'b1 : IMG_W'(row_reg);
        raq = colwrap ? rowq_reg + OUT_IDX_W'(ri[4]) : rowq_reg;
        rar = colwrap ? ri[3:0] : rowr_reg;
        rab = colwrap ? bank_inc(bank_reg) : bank_reg;
        rowwrap = ra >= h_c;
        r  = rowwrap ? '0 : ra[OUT_IDX_W-1:0];
        rq = rowwrap ? '0 : raq;
        rr = rowwrap ? '0 : rar;
        rb = rowwrap ? '0 : rab;

        emit = (DW'(kw_c) <= w_c) && (IMG_W'(kh_c) <= h_c)
               && (DW'(c) + 1'b1 >= DW'(kw_c))
               && (IMG_W'(r) + 1'b1 >= IMG_W'(kh_c))
               && (cr == {1'b0, kdc[2:0]}) && (rr == {1'b0, kdr[2:0]});
        lq     = cq - CW'(kdc[5:3]);
        tq     = rq - OUT_IDX_W'(kdr[5:3]);
        lq_ext = (CW + OUT_IDX_W)'(lq);

        colend = (DW'(c) + 1'b1) >= w_c;
        ci     = rem_inc(cr, s_c);
        ri2    = rem_inc(rr, s_c);
        rnext  = IMG_W'(r) + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            colq_reg <= '0;
            colr_reg <= '0;
            row_reg  <= '0;
            rowq_reg <= '0;
            rowr_reg <= '0;
            bank_reg <= '0;
        end else if (acc_pix) begin
            if (colend) begin
                col_reg  <= '0;
                colq_reg <= '0;
                colr_reg <= '0;
                if (rnext >= h_c) begin
                    row_reg  <= '0;
                    rowq_reg <= '0;
                    rowr_reg <= '0;
                    bank_reg <= '0;
                end else begin
                    row_reg  <= rnext[OUT_IDX_W-1:0];
                    rowq_reg <= rq + OUT_IDX_W'(ri2[4]);
                    rowr_reg <= ri2[3:0];
                    bank_reg <= bank_inc(rb);
                end
            end else begin
                col_reg  <= c + 1'b1;
                colq_reg <= cq + CW'(ci[4]);
                colr_reg <= ci[3:0];
                row_reg  <= r;
                rowq_reg <= rq;
                rowr_reg <= rr;
                bank_reg <= rb;
            end
        end else if (state_reg == SEQ_WAIT && div_done && !recalc) begin
            case (op_reg)
                OP_COL: begin
                    colq_reg <= CW'(div_q);
                    colr_reg <= div_r;
                end
                OP_ROW: begin
                    rowq_reg <= OUT_IDX_W'(div_q);
                    rowr_reg <= div_r;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == SEQ_WAIT && div_done && !recalc) begin
            if (op_reg == OP_WSPAN) qcw_reg <= CW'(div_q);
            if (op_reg == OP_HSPAN) qrh_reg <= OUT_IDX_W'(div_q);
        end
    end

    // ---- line buffers, one bank per kernel row
    logic [DATA_W-1:0] ram_q [MK];

    for (genvar b = 0; b < MK; b++) begin : g_bank
        svc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_WIDTH)) u_line (
            .aclk(aclk),
            .we(acc_pix && (rb == BANK_W'(b))),
            .waddr(c), .wdata(s_value),
            .re(acc_pix), .raddr(c), .rdata(ram_q[b])
        );
    end

    // ---- stage 1 registers
    logic                 p1_emit_reg, p1_last_reg;
    logic [BANK_W-1:0]    p1_bank_reg;
    logic [DATA_W-1:0]    p1_val_reg;
    logic [OUT_IDX_W-1:0] p1_oc_reg, p1_or_reg;
    logic [COEF_AW-1:0]   p1_cidx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_pix_reg  <= 1'b0;
            p1_coef_reg <= 1'b0;
        end else begin
            p1_pix_reg  <= acc_pix;
            p1_coef_reg <= acc_coef;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_emit_reg <= emit;
            p1_last_reg <= (lq == qcw_reg) && (tq == qrh_reg);
            p1_bank_reg <= rb;
            p1_val_reg  <= s_value;
            p1_oc_reg   <= lq_ext[OUT_IDX_W-1:0];
            p1_or_reg   <= tq;
            p1_cidx_reg <= COEF_AW'((int'(s_kernel_select) * MK + int'(s_coef_row)) * MK
                                    + int'(s_coef_col));
        end
    end

    // ---- window columns: age 0 is the current column
    logic [DATA_W-1:0] colsr_reg [MK-1][MK];
    logic [DATA_W-1:0] newcols   [MK][MK];
    logic [BANK_W-1:0] bsel;
    logic [BANK_W-1:0] age, krow;

    always_comb begin
        newcols[0][0] = p1_val_reg;
        for (int k = 1; k < MK; k++) begin
            if (p1_bank_reg >= BANK_W'(k)) bsel = p1_bank_reg - BANK_W'(k);
            else bsel = BANK_W'(int'(p1_bank_reg) + MK - k);
            newcols[0][k] = ram_q[bsel];
        end
        for (int a = 1; a < MK; a++) begin
            for (int k = 0; k < MK; k++) newcols[a][k] = colsr_reg[a-1][k];
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_pix_reg) begin
            for (int a = 0; a < MK - 1; a++) colsr_reg[a] <= newcols[a];
        end
    end

    always_comb begin
        push_job          = '0;
        push_job.kind     = p1_coef_reg ? JOB_COEF : JOB_WIN;
        push_job.coef_idx = p1_cidx_reg;
        push_job.coef_val = p1_val_reg;
        push_job.out_col  = p1_oc_reg;
        push_job.out_row  = p1_or_reg;
        push_job.last     = p1_last_reg;
        for (int i = 0; i < MK; i++) begin
            for (int j = 0; j < MK; j++) begin
                age  = BANK_W'(kw_c - 1'b1 - KSZ_W'(j));
                krow = BANK_W'(kh_c - 1'b1 - KSZ_W'(i));
                if (KSZ_W'(i) < kh_c && KSZ_W'(j) < kw_c) begin
                    push_job.win[i*MK+j] = newcols[age][krow];
                end
            end
        end
    end

    assign push = p1_push_now;
endmodule

// ===== src/svc_back.sv =====
// Back end: applies coefficient jobs and runs window jobs through a
// multiply / row-add / total pipeline into the output register.
// Depends on svc_pkg.
`timescale 1ns / 1ps
module svc_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [svc_pkg::KCNT_W-1:0]   kernel_count,
    input  logic                         fifo_empty,
    input  svc_pkg::job_t                fifo_data,
    output logic                         pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [svc_pkg::SUM_W-1:0]    m_sum,
    output logic [svc_pkg::OUT_IDX_W-1:0] m_out_col,
    output logic [svc_pkg::OUT_IDX_W-1:0] m_out_row,
    output logic                         m_last
);
    import svc_pkg::*;
    localparam int MK = MAX_KERNEL;

    logic en;
    logic [KCNT_W-1:0] kn_c;

    assign en  = !m_valid || m_ready;
    assign pop = en && !fifo_empty;

    always_comb begin
        kn_c = kernel_count;
        if (kernel_count == '0) kn_c = KCNT_W'(1);
        else if (int'(kernel_count) > MAX_KERNELS) kn_c = KCNT_W'(MAX_KERNELS);
    end

    // coefficient store and per-position sum over active kernels
    logic signed [DATA_W-1:0] coef_reg [COEF_N];
    logic signed [CSUM_W-1:0] csum_reg [WIN_N];
    logic signed [CSUM_W-1:0] csum_next [WIN_N];

    always_ff @(posedge aclk) begin
        if (pop && fifo_data.kind == JOB_COEF) begin
            coef_reg[fifo_data.coef_idx] <= fifo_data.coef_val;
        end
    end

    always_comb begin
        for (int p = 0; p < WIN_N; p++) begin
            csum_next[p] = '0;
            for (int k = 0; k < MAX_KERNELS; k++) begin
                if (k < int'(kn_c)) csum_next[p] = csum_next[p] + CSUM_W'(coef_reg[k*WIN_N+p]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        csum_reg <= csum_next;
    end

    // pipeline: A job, B products, C row sums, then output
    logic a_v_reg, b_v_reg, c_v_reg, o_v_reg;
    logic [WIN_N-1:0][DATA_W-1:0] a_win_reg;
    logic signed [PROD_W-1:0] b_prod_reg [WIN_N];
    logic signed [SUM_W-1:0]  c_row_reg  [MK];
    logic signed [SUM_W-1:0]  row_next   [MK];
    logic signed [SUM_W-1:0]  tot_next;
    logic [OUT_IDX_W-1:0] a_oc_reg, b_oc_reg, c_oc_reg, o_oc_reg;
    logic [OUT_IDX_W-1:0] a_or_reg, b_or_reg, c_or_reg, o_or_reg;
    logic a_l_reg, b_l_reg, c_l_reg, o_l_reg;
    logic signed [SUM_W-1:0] o_sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end else if (en) begin
            a_v_reg <= pop && (fifo_data.kind == JOB_WIN);
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            o_v_reg <= c_v_reg;
        end
    end

    always_comb begin
        tot_next = '0;
        for (int i = 0; i < MK; i++) begin
            row_next[i] = '0;
            for (int j = 0; j < MK; j++) begin
                row_next[i] = row_next[i] + SUM_W'(b_prod_reg[i*MK+j]);
            end
            tot_next = tot_next + c_row_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_win_reg <= fifo_data.win;
            a_oc_reg  <= fifo_data.out_col;
            a_or_reg  <= fifo_data.out_row;
            a_l_reg   <= fifo_data.last;
            for (int p = 0; p < WIN_N; p++) begin
                b_prod_reg[p] <= $signed(a_win_reg[p]) * csum_reg[p];
            end
            b_oc_reg  <= a_oc_reg;
            b_or_reg  <= a_or_reg;
            b_l_reg   <= a_l_reg;
            c_row_reg <= row_next;
            c_oc_reg  <= b_oc_reg;
            c_or_reg  <= b_or_reg;
            c_l_reg   <= b_l_reg;
            o_sum_reg <= tot_next;
            o_oc_reg  <= c_oc_reg;
            o_or_reg  <= c_or_reg;
            o_l_reg   <= c_l_reg;
        end
    end

    assign m_valid   = o_v_reg;
    assign m_sum     = o_sum_reg;
    assign m_out_col = o_oc_reg;
    assign m_out_row = o_or_reg;
    assign m_last    = o_l_reg;
endmodule

// ===== src/strided_valid_conv2d_multi_kernel_unit.sv =====
// Strided valid 2D cross-correlation over several kernels, streaming I/O.
// A pixel that closes a window passes the stage 1 registers, the job queue and the A, B, C
// and output registers. Throughput: one beat per cycle, coefficient or pixel, unless a full
// queue or a stride recompute holds s_tready low; the MAC pipeline keeps pace. Reset (sync,
// active low) restores the register defaults and raster origin. After reset and after every
// config write the front recomputes stride phase with a bit-serial divider and holds s_tready low.
// Depends on svc_pkg, svc_front, svc_fifo, svc_back (and their submodules).
`timescale 1ns / 1ps
module strided_valid_conv2d_multi_kernel_unit #(
    parameter int MAX_WIDTH = svc_pkg::DEF_MAX_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [svc_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [svc_pkg::CFG_DW-1:0]     cfg_wdata,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [svc_pkg::S_TDATA_W-1:0]  s_tdata,  // coef_col[2:0] coef_row[5:3] value[21:6]
    input  logic [svc_pkg::S_TUSER_W-1:0]  s_tuser,  // command[0] kernel_select[2:1]
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [svc_pkg::M_TDATA_W-1:0]  m_tdata,  // sum[39:0] out_col[49:40] out_row[59:50]
    output logic                           m_tlast   // last_of_frame
);
    import svc_pkg::*;

    // config registers; out-of-range values are clamped where used
    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width   <= IMG_W'(1024);
            cfg_reg.image_height  <= IMG_W'(1024);
            cfg_reg.kernel_width  <= KSZ_W'(3);
            cfg_reg.kernel_height <= KSZ_W'(3);
            cfg_reg.step_size     <= STEP_W'(1);
            cfg_reg.kernel_count  <= KCNT_W'(1);
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_IMAGE_WIDTH:   cfg_reg.image_width   <= cfg_wdata[IMG_W-1:0];
                REG_IMAGE_HEIGHT:  cfg_reg.image_height  <= cfg_wdata[IMG_W-1:0];
                REG_KERNEL_WIDTH:  cfg_reg.kernel_width  <= cfg_wdata[KSZ_W-1:0];
                REG_KERNEL_HEIGHT: cfg_reg.kernel_height <= cfg_wdata[KSZ_W-1:0];
                REG_STEP_SIZE:     cfg_reg.step_size     <= cfg_wdata[STEP_W-1:0];
                REG_KERNEL_COUNT:  cfg_reg.kernel_count  <= cfg_wdata[KCNT_W-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // front -> queue -> back
    logic push, pop, fifo_empty;
    job_t push_job, pop_job;
    logic [$clog2(FIFO_DEPTH+1)-1:0] fifo_count;
    logic [SUM_W-1:0]     sum;
    logic [OUT_IDX_W-1:0] out_col, out_row;

    svc_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg), .recalc(cfg_we),
        .s_valid(s_tvalid), .s_ready(s_tready),
        .s_command(s_tuser[0]), .s_kernel_select(s_tuser[2:1]),
        .s_coef_col(s_tdata[2:0]), .s_coef_row(s_tdata[5:3]), .s_value(s_tdata[21:6]),
        .fifo_count(fifo_count), .push(push), .push_job(push_job)
    );

    svc_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .aclk(aclk), .aresetn(aresetn), .push(push), .push_data(push_job),
        .pop(pop), .pop_data(pop_job), .empty(fifo_empty), .count(fifo_count)
    );

    svc_back u_back (
        .aclk(aclk), .aresetn(aresetn), .kernel_count(cfg_reg.kernel_count),
        .fifo_empty(fifo_empty), .fifo_data(pop_job), .pop(pop),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_sum(sum),
        .m_out_col(out_col), .m_out_row(out_row), .m_last(m_tlast)
    );

    assign m_tdata = {4'd0, out_row, out_col, sum};
endmodule

// ===== src/svc_checker.sv =====
// Port-level checks for the convolution unit, bound onto the top level.
// Depends on svc_pkg.
`timescale 1ns / 1ps
module svc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          cfg_we,
    input logic [svc_pkg::CFG_AW-1:0]    cfg_addr,
    input logic [svc_pkg::CFG_DW-1:0]    cfg_wdata,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [svc_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [svc_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [svc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);
    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat dropped or changed under stall");

    // reset empties the output register
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // no beat taken in the cycle of a config write
    a_cfg_now: assert property (@(posedge aclk) cfg_we |-> !s_tready)
        else $error("input ready during config write");

    // stride recompute follows every config write
    a_cfg_next: assert property (@(posedge aclk) cfg_we |=> !s_tready)
        else $error("input ready before stride recompute");
endmodule

bind strided_valid_conv2d_multi_kernel_unit svc_checker u_svc_checker (.*);

// ===== tb/sv/testbench.sv =====
// Self-checking bench for the strided multi-kernel 2D convolution unit.
// Depends on svc_pkg and strided_valid_conv2d_multi_kernel_unit; needs nothing else.
`timescale 1ns / 1ps

typedef struct {
    logic [39:0] sum;
    logic [9:0]  col;
    logic [9:0]  row;
    logic        last;
} conv_result_t;

// Tracks the expected convolution results: a bit-true predictor of the unit
// plus the queue of results still owed by the hardware.
class conv_scoreboard;
    logic [10:0] img_w, img_h;
    logic [2:0]  k_w, k_h, k_cnt;
    logic [3:0]  step;
    logic signed [15:0] coefs [100];
    logic signed [15:0] lines [5*1024];
    int unsigned col_pos, row_pos;
    conv_result_t owed_q [$];
    int errors;
    int results_seen;

    function new();
        img_w = 11'd1024; img_h = 11'd1024;
        k_w = 3'd3; k_h = 3'd3; step = 4'd1; k_cnt = 3'd1;
        foreach (coefs[i]) coefs[i] = '0;
        foreach (lines[i]) lines[i] = '0;
        col_pos = 0; row_pos = 0;
        errors = 0; results_seen = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [10:0] d);
        case (idx)
            svc_pkg::REG_IMAGE_WIDTH:   img_w = d;
            svc_pkg::REG_IMAGE_HEIGHT:  img_h = d;
            svc_pkg::REG_KERNEL_WIDTH:  k_w   = d[2:0];
            svc_pkg::REG_KERNEL_HEIGHT: k_h   = d[2:0];
            svc_pkg::REG_STEP_SIZE:     step  = d[3:0];
            svc_pkg::REG_KERNEL_COUNT:  k_cnt = d[2:0];
            default: ;
        endcase
    endfunction

    function bit at_origin();
        return col_pos == 0 && row_pos == 0;
    endfunction

    function int pending();
        return owed_q.size();
    endfunction

    // Applies one accepted input beat and queues the result it causes, if any.
    function void note_beat(logic cmd, logic [1:0] ksel, logic [2:0] cc, logic [2:0] cr,
                            logic signed [15:0] v);
        int w, h, kw, kh, s, kn, c, r, left, top;
        longint acc;
        conv_result_t res;
        w  = (img_w == 0) ? 1 : (img_w > 1024) ? 1024 : int'(img_w);
        h  = (img_h == 0) ? 1 : (img_h > 1024) ? 1024 : int'(img_h);
        kw = (k_w == 0) ? 1 : (k_w > 5) ? 5 : int'(k_w);
        kh = (k_h == 0) ? 1 : (k_h > 5) ? 5 : int'(k_h);
        s  = (step == 0) ? 1 : int'(step);
        kn = (k_cnt == 0) ? 1 : (k_cnt > 4) ? 4 : int'(k_cnt);
        if (cmd == svc_pkg::CMD_COEF) begin
            if (cc < 5 && cr < 5) coefs[(int'(ksel) * 5 + int'(cr)) * 5 + int'(cc)] = v;
            return;
        end
        // geometry may have shrunk under the current position
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        c = col_pos;
        r = row_pos;
        lines[(r % 5) * 1024 + c] = v;
        if (kw <= w && kh <= h && c + 1 >= kw && r + 1 >= kh) begin
            left = c + 1 - kw;
            top  = r + 1 - kh;
            if (left % s == 0 && top % s == 0) begin
                acc = 0;
                for (int i = 0; i < kh; i++)
                    for (int j = 0; j < kw; j++)
                        for (int k = 0; k < kn; k++)
                            acc += longint'(lines[((top + i) % 5) * 1024 + left + j]) *
                                   longint'(coefs[(k * 5 + i) * 5 + j]);
                res.sum  = acc[39:0];
                res.col  = 10'(left / s);
                res.row  = 10'(top / s);
                res.last = (left / s == (w - kw) / s) && (top / s == (h - kh) / s);
                owed_q.push_back(res);
            end
        end
        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) row_pos = 0;
        end
    endfunction

    task report(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task check_result(logic [63:0] d, logic last);
        conv_result_t e;
        results_seen++;
        if (owed_q.size() == 0) begin
            report($sformatf("unexpected result beat %h", d));
            return;
        end
        e = owed_q.pop_front();
        if (d[39:0] !== e.sum)
            report($sformatf("sum %h, expected %h", d[39:0], e.sum));
        if (d[49:40] !== e.col)
            report($sformatf("out_col %0d, expected %0d", d[49:40], e.col));
        if (d[59:50] !== e.row)
            report($sformatf("out_row %0d, expected %0d", d[59:50], e.row));
        if (last !== e.last)
            report($sformatf("last_of_frame %b, expected %b", last, e.last));
    endtask
endclass

module testbench;
    import svc_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_AW-1:0]    cfg_addr;
    logic [CFG_DW-1:0]    cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // coef_col[2:0] coef_row[5:3] value[21:6]
    logic [S_TUSER_W-1:0] s_tuser;   // command[0] kernel_select[2:1]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // sum[39:0] out_col[49:40] out_row[59:50]
    logic                 m_tlast;   // last_of_frame

    conv_scoreboard sb;
    bit     no_idle;        // phases with back-to-back traffic on both sides
    bit     hold_done;
    int     rx_hold;
    int     rx_gap;
    longint cycles;

    strided_valid_conv2d_multi_kernel_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: a hang or a lost beat ends here.
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 97) return $urandom_range(1, 3);
        return $urandom_range(20, 80);
    endfunction

    // Result side: random back-pressure plus one long hold-off once traffic is flowing.
    initial begin
        m_tready = 1'b0;
        rx_hold = 0;
        rx_gap = 0;
        hold_done = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
            if (!hold_done && sb.results_seen >= 40) begin
                hold_done = 1;
                rx_hold = 400;   // input side keeps offering; unit must fill and stall
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                rx_gap = pick_gap();
            end
        end
    end

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] d);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= d;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, d);
    endtask

    // One input beat; returns after the handshake, then maybe drops valid for a gap.
    task automatic send_beat(logic cmd, logic [1:0] ksel, logic [2:0] cc, logic [2:0] cr,
                             logic [15:0] v);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, v, cr, cc};
        s_tuser  <= {ksel, cmd};
        do @(posedge aclk); while (!s_tready);
        sb.note_beat(cmd, ksel, cc, cr, v);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 19))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_pixel();
        send_beat(CMD_PIXEL, 2'($urandom), 3'($urandom), 3'($urandom), pick_value());
    endtask

    // Config only while quiet: every result in, then room for the pipeline to drain.
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_geometry(int w, int h, int kw, int kh, int s, int kn);
        wait_quiet();
        write_reg(REG_IMAGE_WIDTH, 11'(w));
        write_reg(REG_IMAGE_HEIGHT, 11'(h));
        write_reg(REG_KERNEL_WIDTH, 11'(kw));
        write_reg(REG_KERNEL_HEIGHT, 11'(kh));
        write_reg(REG_STEP_SIZE, 11'(s));
        write_reg(REG_KERNEL_COUNT, 11'(kn));
    endtask

    // Finish the current frame so the next config starts at the raster origin.
    task automatic finish_frame();
        do send_pixel(); while (!sb.at_origin());
    endtask

    task automatic run_frames(int w, int h, int kw, int kh, int s, int kn, int frames,
                              bit coef_noise);
        int n;
        set_geometry(w, h, kw, kh, s, kn);
        n = frames * sb.img_w;   // raw size; clamping is absorbed by finish_frame
        for (int i = 0; i < n; i++) begin
            if (coef_noise && $urandom_range(0, 19) == 0)
                send_beat(CMD_COEF, 2'($urandom), 3'($urandom), 3'($urandom), pick_value());
            else
                send_pixel();
        end
        finish_frame();
    endtask

    initial begin
        int sent;
        sb = new();
        no_idle   = 0;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every coefficient slot gets a value, extremes included
        for (int k = 0; k < 4; k++)
            for (int r = 0; r < 5; r++)
                for (int c = 0; c < 5; c++)
                    send_beat(CMD_COEF, 2'(k), 3'(c), 3'(r),
                              (k == 0 && r == 0 && c == 0) ? 16'h8000 :
                              (k == 3 && r == 4 && c == 4) ? 16'h7fff : pick_value());
        // loads outside the kernel grid are dropped
        send_beat(CMD_COEF, 2'd1, 3'd7, 3'd2, 16'h1234);
        send_beat(CMD_COEF, 2'd2, 3'd1, 3'd5, 16'h4321);
        send_beat(CMD_COEF, 2'd3, 3'd6, 3'd6, 16'hffff);

        // directed geometries
        run_frames(8, 3, 3, 3, 1, 1, 3, 0);
        run_frames(1, 1, 1, 1, 1, 4, 4, 0);     // smallest frame, all kernels
        run_frames(4, 4, 5, 5, 2, 2, 4, 0);     // kernel larger than image: no results
        run_frames(6, 5, 5, 1, 8, 3, 5, 0);
        no_idle = 1;
        run_frames(1024, 2, 5, 2, 8, 4, 2, 0);  // widest row
        no_idle = 0;
        run_frames(1, 1024, 1, 5, 3, 1, 1, 0);  // tallest frame
        run_frames(2047, 0, 7, 0, 0, 7, 1, 0);  // out-of-range values saturate
        run_frames(9, 7, 6, 4, 15, 0, 7, 0);

        // geometry shrunk mid-frame: the next pixel wraps to the frame origin
        set_geometry(10, 8, 3, 2, 1, 2);
        repeat (38) send_pixel();
        set_geometry(6, 3, 2, 2, 1, 2);
        finish_frame();

        // random geometries, mostly small, with stray coefficient reloads
        sent = 0;
        while (sent < 2000) begin
            no_idle = ($urandom_range(0, 4) == 0);
            run_frames($urandom_range(1, 16), $urandom_range(1, 12), $urandom_range(0, 7),
                       $urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 7),
                       $urandom_range(1, 4), 1);
            sent += 4 * 12;
        end

        wait_quiet();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
